// ----- hdl/mlpt_pkg.sv -----
// ----------------------------------------------------------------------------
// mlpt_pkg
// Shared types, codes and fixed-point helpers for the two-layer MLP trainer.
// ----------------------------------------------------------------------------
package mlpt_pkg;

  localparam int NUM_FEATURES_DEF = 128;
  localparam int NUM_HIDDEN_DEF   = 32;

  localparam logic [15:0] LR_RESET = 16'd655;

  localparam logic [2:0] FN_W1    = 3'd0;
  localparam logic [2:0] FN_B1    = 3'd1;
  localparam logic [2:0] FN_W2    = 3'd2;
  localparam logic [2:0] FN_B2    = 3'd3;
  localparam logic [2:0] FN_FEAT  = 3'd4;
  localparam logic [2:0] FN_EVAL  = 3'd5;
  localparam logic [2:0] FN_TRAIN = 3'd6;

  typedef struct packed {
    logic accept;
    logic f_init;
    logic f_mac;
    logic f_act;
    logic f_out;
    logic f_score;
    logic t_e;
    logic t_es;
    logic t_s;
    logic t_sr;
    logic t_b;
    logic t_wr;
    logic t_w2;
  } mlpt_cmd_t;

  typedef struct packed {
    logic h_pos;
  } mlpt_sts_t;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
    logic signed [63:0] half;
    half = 64'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ----- hdl/mlpt_ram.sv -----
// ----------------------------------------------------------------------------
// mlpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mlpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/mlpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlpt_ctrl
// Sequencer for the forward pass and the gradient step; owns the loop counters.
// ----------------------------------------------------------------------------
`default_nettype none
module mlpt_ctrl
  import mlpt_pkg::*;
#(
  parameter int NUM_FEATURES = NUM_FEATURES_DEF,
  parameter int NUM_HIDDEN   = NUM_HIDDEN_DEF,
  localparam int JW = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1,
  localparam int IW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [2:0]    in_func,
  output logic               busy,
  output mlpt_cmd_t          cmd,
  input  wire mlpt_sts_t     sts,
  output logic [JW-1:0]      j_idx,
  output logic [IW-1:0]      i_idx
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FLD    = 5'd1;
  localparam logic [4:0] S_FINIT  = 5'd2;
  localparam logic [4:0] S_FRD    = 5'd3;
  localparam logic [4:0] S_FMAC   = 5'd4;
  localparam logic [4:0] S_FACT   = 5'd5;
  localparam logic [4:0] S_FOUT   = 5'd6;
  localparam logic [4:0] S_FSCORE = 5'd7;
  localparam logic [4:0] S_TE     = 5'd8;
  localparam logic [4:0] S_TES    = 5'd9;
  localparam logic [4:0] S_TLD    = 5'd10;
  localparam logic [4:0] S_TS     = 5'd11;
  localparam logic [4:0] S_TSR    = 5'd12;
  localparam logic [4:0] S_TB     = 5'd13;
  localparam logic [4:0] S_TRD    = 5'd14;
  localparam logic [4:0] S_TWR    = 5'd15;
  localparam logic [4:0] S_TW2    = 5'd16;

  localparam logic [JW-1:0] J_LAST = JW'(NUM_HIDDEN - 1);
  localparam logic [IW-1:0] I_LAST = IW'(NUM_FEATURES - 1);

  logic [4:0]    state_r, state_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic          train_r, train_nxt;
  logic          acc_go;

  assign busy   = (state_r != S_IDLE);
  assign acc_go = start && !busy;
  assign j_idx  = j_r;
  assign i_idx  = i_r;

  always_comb begin
    cmd         = '0;
    cmd.accept  = acc_go;
    cmd.f_init  = (state_r == S_FINIT);
    cmd.f_mac   = (state_r == S_FMAC);
    cmd.f_act   = (state_r == S_FACT);
    cmd.f_out   = (state_r == S_FOUT);
    cmd.f_score = (state_r == S_FSCORE);
    cmd.t_e     = (state_r == S_TE);
    cmd.t_es    = (state_r == S_TES);
    cmd.t_s     = (state_r == S_TS);
    cmd.t_sr    = (state_r == S_TSR);
    cmd.t_b     = (state_r == S_TB);
    cmd.t_wr    = (state_r == S_TWR);
    cmd.t_w2    = (state_r == S_TW2);
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    train_nxt = train_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_go && (in_func == FN_EVAL || in_func == FN_TRAIN)) begin
          train_nxt = (in_func == FN_TRAIN);
          j_nxt     = '0;
          i_nxt     = '0;
          state_nxt = S_FLD;
        end
      end
      S_FLD:   state_nxt = S_FINIT;
      S_FINIT: begin
        i_nxt     = '0;
        state_nxt = S_FRD;
      end
      S_FRD:   state_nxt = S_FMAC;
      S_FMAC: begin
        if (i_r == I_LAST) begin
          state_nxt = S_FACT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_FACT:  state_nxt = S_FOUT;
      S_FOUT: begin
        if (j_r == J_LAST) begin
          state_nxt = S_FSCORE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_FLD;
        end
      end
      S_FSCORE: state_nxt = train_r ? S_TE : S_IDLE;
      S_TE:    state_nxt = S_TES;
      S_TES: begin
        j_nxt     = '0;
        state_nxt = S_TLD;
      end
      S_TLD:   state_nxt = S_TS;
      S_TS:    state_nxt = S_TSR;
      S_TSR:   state_nxt = S_TB;
      S_TB: begin
        i_nxt     = '0;
        state_nxt = sts.h_pos ? S_TRD : S_TW2;
      end
      S_TRD:   state_nxt = S_TWR;
      S_TWR: begin
        if (i_r == I_LAST) begin
          state_nxt = S_TW2;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_TW2: begin
        if (j_r == J_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_TLD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
      i_r     <= '0;
      train_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
      train_r <= train_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mlpt_dp.sv -----
// ----------------------------------------------------------------------------
// mlpt_dp
// Weight, bias and feature stores, MAC unit and update arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
module mlpt_dp
  import mlpt_pkg::*;
#(
  parameter int NUM_FEATURES = NUM_FEATURES_DEF,
  parameter int NUM_HIDDEN   = NUM_HIDDEN_DEF,
  localparam int JW  = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1,
  localparam int IW  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1,
  localparam int W1D = NUM_HIDDEN * NUM_FEATURES,
  localparam int AW1 = (W1D > 1) ? $clog2(W1D) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mlpt_cmd_t          cmd,
  output mlpt_sts_t               sts,
  input  wire logic [JW-1:0]      j_idx,
  input  wire logic [IW-1:0]      i_idx,
  input  wire logic [2:0]         in_func,
  input  wire logic [4:0]         in_row,
  input  wire logic [6:0]         in_col,
  input  wire logic signed [15:0] in_value,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  output logic                    out_valid,
  output logic signed [15:0]      out_score
);

  localparam int ACC_W  = 34 + IW;
  localparam int ACC2_W = 34 + JW;

  logic [15:0]              lr_r;
  logic signed [15:0]       b2_r;
  logic [NUM_HIDDEN-1:0]    b1_vld_r;
  logic                     b1_ok_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC2_W-1:0] acc2_r;
  logic signed [15:0]       h_r, w2_r, b1_r, target_r, score_r;
  logic signed [33:0]       pe_r;
  logic signed [17:0]       es_r;
  logic signed [49:0]       sprod_r;
  logic signed [21:0]       s_r;
  logic                     out_valid_r;

  logic row_ok, col_ok;
  logic [31:0] in_w1_addr, dp_w1_addr;
  logic [JW-1:0] in_j;
  logic [IW-1:0] in_i;

  logic [15:0] w1_rd, x_rd, b1_rd, w2_rd, hid_rd;
  logic signed [15:0] w1_s, x_s, b1_val, w2_s, hid_s;

  logic          w1_we, b1_we, w2_we, x_we;
  logic [AW1-1:0] w1_waddr;
  logic [JW-1:0] b1_waddr, w2_waddr;
  logic [15:0]   w1_wdata, b1_wdata, w2_wdata;

  logic signed [31:0] mac_prod;
  logic signed [15:0] h_new, w1_new, w2_new, b1_new;
  logic signed [16:0] e_val;

  assign row_ok     = 32'(in_row) < 32'(NUM_HIDDEN);
  assign col_ok     = 32'(in_col) < 32'(NUM_FEATURES);
  assign in_w1_addr = 32'(in_row) * 32'(NUM_FEATURES) + 32'(in_col);
  assign dp_w1_addr = 32'(j_idx) * 32'(NUM_FEATURES) + 32'(i_idx);
  assign in_j       = JW'(in_row);
  assign in_i       = IW'(in_col);

  assign w1_s   = w1_rd;
  assign x_s    = x_rd;
  assign w2_s   = w2_rd;
  assign hid_s  = hid_rd;
  assign b1_val = b1_ok_r ? b1_rd : 16'sd0;

  assign mac_prod = w1_s * x_s;
  assign h_new    = (acc_r <= 0) ? 16'sd0 : sat16(rnd(64'(acc_r), 12));
  assign w1_new   = sat16(64'(w1_s) - rnd(64'(s_r * x_s), 12));
  assign w2_new   = sat16(64'(w2_r) - rnd(64'(es_r * h_r), 12));
  assign b1_new   = sat16(64'(b1_r) - 64'(s_r));
  assign e_val    = 17'(score_r) - 17'(target_r);

  assign sts.h_pos = (h_r > 0);

  always_comb begin
    w1_we    = 1'b0;
    w1_waddr = dp_w1_addr[AW1-1:0];
    w1_wdata = w1_new;
    b1_we    = 1'b0;
    b1_waddr = j_idx;
    b1_wdata = b1_new;
    w2_we    = 1'b0;
    w2_waddr = j_idx;
    w2_wdata = w2_new;
    x_we     = 1'b0;
    if (cmd.accept) begin
      w1_waddr = in_w1_addr[AW1-1:0];
      w1_wdata = in_value;
      b1_waddr = in_j;
      b1_wdata = in_value;
      w2_waddr = in_j;
      w2_wdata = in_value;
      w1_we    = (in_func == FN_W1) && row_ok && col_ok;
      b1_we    = (in_func == FN_B1) && row_ok;
      w2_we    = (in_func == FN_W2) && row_ok;
      x_we     = (in_func == FN_FEAT) && col_ok;
    end else begin
      w1_we = cmd.t_wr;
      b1_we = cmd.t_b && sts.h_pos;
      w2_we = cmd.t_w2;
    end
  end

  mlpt_ram #(.WIDTH(16), .DEPTH(W1D)) u_w1 (
    .clk(clk), .we(w1_we), .waddr(w1_waddr), .wdata(w1_wdata),
    .raddr(dp_w1_addr[AW1-1:0]), .rdata(w1_rd)
  );

  mlpt_ram #(.WIDTH(16), .DEPTH(NUM_FEATURES)) u_x (
    .clk(clk), .we(x_we), .waddr(in_i), .wdata(in_value),
    .raddr(i_idx), .rdata(x_rd)
  );

  mlpt_ram #(.WIDTH(16), .DEPTH(NUM_HIDDEN)) u_b1 (
    .clk(clk), .we(b1_we), .waddr(b1_waddr), .wdata(b1_wdata),
    .raddr(j_idx), .rdata(b1_rd)
  );

  mlpt_ram #(.WIDTH(16), .DEPTH(NUM_HIDDEN)) u_w2 (
    .clk(clk), .we(w2_we), .waddr(w2_waddr), .wdata(w2_wdata),
    .raddr(j_idx), .rdata(w2_rd)
  );

  mlpt_ram #(.WIDTH(16), .DEPTH(NUM_HIDDEN)) u_hid (
    .clk(clk), .we(cmd.f_act), .waddr(j_idx), .wdata(h_new),
    .raddr(j_idx), .rdata(hid_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r        <= LR_RESET;
      b2_r        <= '0;
      b1_vld_r    <= '0;
      b1_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) lr_r <= cfg_wdata;
      b1_ok_r     <= b1_vld_r[j_idx];
      out_valid_r <= cmd.f_score;
      if (b1_we) b1_vld_r[b1_waddr] <= 1'b1;
      if (cmd.accept && in_func == FN_B2) b2_r <= in_value;
      else if (cmd.t_es) b2_r <= sat16(64'(b2_r) - 64'(rnd(64'(pe_r), 16)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      target_r <= in_value;
      acc2_r   <= ACC2_W'(b2_r) <<< 12;
    end
    if (cmd.f_init) acc_r <= ACC_W'(b1_val) <<< 12;
    if (cmd.f_mac)  acc_r <= acc_r + ACC_W'(mac_prod);
    if (cmd.f_act)  h_r   <= h_new;
    if (cmd.f_out)  acc2_r <= acc2_r + ACC2_W'(w2_s * h_r);
    if (cmd.f_score) score_r <= sat16(rnd(64'(acc2_r), 12));
    if (cmd.t_e)    pe_r  <= $signed({1'b0, lr_r}) * e_val;
    if (cmd.t_es)   es_r  <= 18'(rnd(64'(pe_r), 16));
    if (cmd.t_s) begin
      sprod_r <= pe_r * w2_s;
      h_r     <= hid_s;
      w2_r    <= w2_s;
      b1_r    <= b1_val;
    end
    if (cmd.t_sr)   s_r   <= 22'(rnd(64'(sprod_r), 28));
  end

  assign out_valid = out_valid_r;
  assign out_score = score_r;

endmodule
`default_nettype wire

// ----- hdl/mlp_relu_train_step.sv -----
// ----------------------------------------------------------------------------
// mlp_relu_train_step
// Two-layer ReLU perceptron with one SGD step per train command, Q4.12 data.
//
//  channel | ports                                  | handshake
//  input   | in_func in_row in_col in_value         | start, busy
//  result  | out_score                              | out_valid strobe
//  config  | cfg_wdata                              | cfg_we
//
// Write commands are taken while the block stays idle. Evaluate runs the
// forward pass over every hidden neuron; train then adds a gradient step that
// updates layer-one weights and biases only where the hidden value is positive.
// Score strobes in the cycle after the forward pass; the receiver cannot stall.
// Reset is synchronous; weights, output weights and features are undefined
// until written, hidden biases read as zero until written.
// ----------------------------------------------------------------------------
`default_nettype none
module mlp_relu_train_step
  import mlpt_pkg::*;
#(
  parameter int NUM_FEATURES = NUM_FEATURES_DEF,
  parameter int NUM_HIDDEN   = NUM_HIDDEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_func,
  input  wire logic [4:0]         in_row,
  input  wire logic [6:0]         in_col,
  input  wire logic signed [15:0] in_value,
  output logic                    out_valid,
  output logic signed [15:0]      out_score,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int JW = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
  localparam int IW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

  mlpt_cmd_t     cmd;
  mlpt_sts_t     sts;
  logic [JW-1:0] j_idx;
  logic [IW-1:0] i_idx;

  mlpt_ctrl #(.NUM_FEATURES(NUM_FEATURES), .NUM_HIDDEN(NUM_HIDDEN)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_func(in_func), .busy(busy),
    .cmd(cmd), .sts(sts), .j_idx(j_idx), .i_idx(i_idx)
  );

  mlpt_dp #(.NUM_FEATURES(NUM_FEATURES), .NUM_HIDDEN(NUM_HIDDEN)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .j_idx(j_idx), .i_idx(i_idx),
    .in_func(in_func), .in_row(in_row), .in_col(in_col), .in_value(in_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_score(out_score)
  );

endmodule
`default_nettype wire
